[rtl/swam_pkg.sv]
// Shared constants and types for the sliding window anagram match unit.
package swam_pkg;

    localparam int LETTER_W = 5;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int ALPHABET_DEF    = 26;
    localparam int OUTQ_DEPTH      = 4;

    typedef struct packed {
        logic window_match;
        logic found;
        logic pattern_full;
    } swam_result_t;

    // One item on its way from the front end to the histogram update
    typedef struct packed {
        logic                valid;
        logic                clear;
        logic                text;
        logic                pattern;
        logic                drop;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] leave;
        logic                full_flag;
    } swam_stage_t;

endpackage

[rtl/swam_if.sv]
// Handshake channels of the sliding window anagram match unit.
interface swam_in_if import swam_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, op, letter, input ready);
    modport sink   (input valid, op, letter, output ready);
endinterface

interface swam_out_if import swam_pkg::*; ();
    logic valid;
    logic ready;
    logic window_match;
    logic found;
    logic pattern_full;

    modport source (output valid, window_match, found, pattern_full, input ready);
    modport sink   (input valid, window_match, found, pattern_full, output ready);
endinterface

[rtl/swam_ctrl.sv]
// Front end: op decode, pattern length, window fill, ring of recent text letters.
module swam_ctrl import swam_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int ALPHABET    = ALPHABET_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [OP_W-1:0]     op,
    input  logic [LETTER_W-1:0] letter,
    output swam_stage_t         stage
);

    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int DW = FW + 1;

    logic [FW-1:0] plen_reg, plen_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [RW-1:0] wp_reg, wp_next;
    logic          full_reg, full_next;
    logic          zero_reg;
    swam_stage_t   s1_reg, s1_next;

    logic                letter_ok;
    logic                ring_we;
    logic [DW-1:0]       ring_dist;
    logic [RW-1:0]       ring_raddr;
    logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
    logic [LETTER_W-1:0] ring_rd_reg;

    assign letter_ok = 32'(letter) < ALPHABET;

    // Decode the beat and advance the control state
    always_comb
    begin
        plen_next = plen_reg;
        fill_next = fill_reg;
        wp_next   = wp_reg;
        full_next = full_reg;
        ring_we   = 1'b0;
        s1_next   = '0;
        s1_next.valid  = accept;
        s1_next.letter = letter;
        s1_next.leave  = letter;
        if (accept)
        begin
            case (op)
                OP_CLEAR:
                begin
                    plen_next     = '0;
                    fill_next     = '0;
                    wp_next       = '0;
                    full_next     = 1'b0;
                    s1_next.clear = 1'b1;
                end
                OP_PATTERN:
                begin
                    if (letter_ok)
                    begin
                        if (plen_reg < FW'(MAX_PATTERN))
                        begin
                            plen_next       = plen_reg + FW'(1);
                            s1_next.pattern = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                end
                OP_TEXT:
                begin
                    if (letter_ok)
                    begin
                        s1_next.text = 1'b1;
                        ring_we      = 1'b1;
                        wp_next      = (wp_reg == RW'(MAX_PATTERN - 1)) ? '0 : wp_reg + RW'(1);
                        if (fill_reg == plen_reg)
                        begin
                            s1_next.drop = 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                end
                OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
        s1_next.full_flag = full_next;
    end

    // Ring slot of the oldest letter in the window
    always_comb
    begin
        ring_dist = DW'(wp_reg) - DW'(fill_reg);
        if (ring_dist[DW-1])
        begin
            ring_raddr = RW'(ring_dist + DW'(MAX_PATTERN));
        end
        else
        begin
            ring_raddr = RW'(ring_dist);
        end
    end

    // Ring memory: read the leaving letter before this beat overwrites its slot
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= letter;
        end
        if (accept)
        begin
            ring_rd_reg <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            fill_reg <= '0;
            wp_reg   <= '0;
            full_reg <= 1'b0;
            zero_reg <= 1'b0;
            s1_reg   <= '0;
        end
        else
        begin
            plen_reg <= plen_next;
            fill_reg <= fill_next;
            wp_reg   <= wp_next;
            full_reg <= full_next;
            zero_reg <= (plen_reg == '0);
            s1_reg   <= s1_next;
        end
    end

    // With an empty pattern the new letter leaves at once
    always_comb
    begin
        stage = s1_reg;
        if (!zero_reg)
        begin
            stage.leave = ring_rd_reg;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= plen_reg && plen_reg <= FW'(MAX_PATTERN))
        else $error("window fill beyond pattern length");

endmodule

[rtl/swam_hist.sv]
// Histogram difference memories with read-modify-write and mismatch counting.
module swam_hist import swam_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int ALPHABET    = ALPHABET_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  swam_stage_t  stage,
    output logic         res_valid,
    output swam_result_t res,
    output logic         busy
);

    localparam int AW = $clog2(ALPHABET);
    localparam int CW = $clog2(MAX_PATTERN + 2) + 1;
    localparam int NW = $clog2(ALPHABET + 1);

    // pin_mem counts text letters in minus pattern letters, out_mem letters dropped;
    // their difference mod 2^CW is window count minus pattern count
    logic [CW-1:0] pin_mem [ALPHABET];
    logic [CW-1:0] out_mem [ALPHABET];
    logic [CW-1:0] pin_a_reg, pin_b_reg, out_a_reg, out_b_reg;
    logic [ALPHABET-1:0] pin_vld_reg, out_vld_reg;

    logic          fwd_pin_v_reg, fwd_out_v_reg;
    logic [AW-1:0] fwd_pin_addr_reg, fwd_out_addr_reg;
    logic [CW-1:0] fwd_pin_data_reg, fwd_out_data_reg;

    swam_stage_t   s2_reg;
    logic [NW-1:0] nz_reg, nz_next;
    logic          found_reg, found_next;

    logic [AW-1:0] rd_a, rd_b, addr_a, addr_b;
    logic [CW-1:0] pin_a, pin_b, out_a, out_b;
    logic [CW-1:0] diff_a, diff_b, new_a, new_b;
    logic          pin_we, out_we, match;
    logic [CW-1:0] pin_wdata, out_wdata;

    assign rd_a   = AW'(stage.letter);
    assign rd_b   = AW'(stage.leave);
    assign addr_a = AW'(s2_reg.letter);
    assign addr_b = AW'(s2_reg.leave);

    // Synchronous memories, one write and two reads each
    always_ff @(posedge clk)
    begin
        if (pin_we)
        begin
            pin_mem[addr_a] <= pin_wdata;
        end
        if (out_we)
        begin
            out_mem[addr_b] <= out_wdata;
        end
        pin_a_reg <= pin_mem[rd_a];
        pin_b_reg <= pin_mem[rd_b];
        out_a_reg <= out_mem[rd_a];
        out_b_reg <= out_mem[rd_b];
    end

    // Forward last cycle's write, else the memory word, else the cleared value
    always_comb
    begin
        if (fwd_pin_v_reg && fwd_pin_addr_reg == addr_a)
            pin_a = fwd_pin_data_reg;
        else
            pin_a = pin_vld_reg[addr_a] ? pin_a_reg : '0;
        if (fwd_pin_v_reg && fwd_pin_addr_reg == addr_b)
            pin_b = fwd_pin_data_reg;
        else
            pin_b = pin_vld_reg[addr_b] ? pin_b_reg : '0;
        if (fwd_out_v_reg && fwd_out_addr_reg == addr_a)
            out_a = fwd_out_data_reg;
        else
            out_a = out_vld_reg[addr_a] ? out_a_reg : '0;
        if (fwd_out_v_reg && fwd_out_addr_reg == addr_b)
            out_b = fwd_out_data_reg;
        else
            out_b = out_vld_reg[addr_b] ? out_b_reg : '0;
    end

    assign diff_a = pin_a - out_a;
    assign diff_b = pin_b - out_b;

    // Modify the counts and track how many letters differ
    always_comb
    begin
        pin_we     = 1'b0;
        out_we     = 1'b0;
        pin_wdata  = pin_a;
        out_wdata  = out_b;
        new_a      = diff_a;
        new_b      = diff_b;
        nz_next    = nz_reg;
        found_next = found_reg;
        match      = 1'b0;
        if (s2_reg.valid)
        begin
            if (s2_reg.clear)
            begin
                nz_next    = '0;
                found_next = 1'b0;
            end
            else if (s2_reg.pattern)
            begin
                pin_we    = 1'b1;
                pin_wdata = pin_a - CW'(1);
                new_a     = diff_a - CW'(1);
                if (diff_a == '0 && new_a != '0)
                    nz_next = nz_next + NW'(1);
                if (diff_a != '0 && new_a == '0)
                    nz_next = nz_next - NW'(1);
            end
            else if (s2_reg.text)
            begin
                pin_we    = 1'b1;
                pin_wdata = pin_a + CW'(1);
                new_a     = diff_a + CW'(1);
                if (s2_reg.drop)
                begin
                    out_we    = 1'b1;
                    out_wdata = out_b + CW'(1);
                    new_b     = diff_b - CW'(1);
                end
                if (!(s2_reg.drop && addr_a == addr_b))
                begin
                    if (diff_a == '0 && new_a != '0)
                        nz_next = nz_next + NW'(1);
                    if (diff_a != '0 && new_a == '0)
                        nz_next = nz_next - NW'(1);
                    if (s2_reg.drop)
                    begin
                        if (diff_b == '0 && new_b != '0)
                            nz_next = nz_next + NW'(1);
                        if (diff_b != '0 && new_b == '0)
                            nz_next = nz_next - NW'(1);
                    end
                end
                match = (nz_next == '0);
                if (match)
                    found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg           <= '0;
            nz_reg           <= '0;
            found_reg        <= 1'b0;
            pin_vld_reg      <= '0;
            out_vld_reg      <= '0;
            fwd_pin_v_reg    <= 1'b0;
            fwd_out_v_reg    <= 1'b0;
            fwd_pin_addr_reg <= '0;
            fwd_out_addr_reg <= '0;
            fwd_pin_data_reg <= '0;
            fwd_out_data_reg <= '0;
        end
        else
        begin
            s2_reg        <= stage;
            nz_reg        <= nz_next;
            found_reg     <= found_next;
            fwd_pin_v_reg <= pin_we;
            fwd_out_v_reg <= out_we;
            if (pin_we)
            begin
                fwd_pin_addr_reg <= addr_a;
                fwd_pin_data_reg <= pin_wdata;
            end
            if (out_we)
            begin
                fwd_out_addr_reg <= addr_b;
                fwd_out_data_reg <= out_wdata;
            end
            // Drop every stored count at once on clear
            if (s2_reg.valid && s2_reg.clear)
            begin
                pin_vld_reg <= '0;
                out_vld_reg <= '0;
            end
            else
            begin
                if (pin_we)
                    pin_vld_reg[addr_a] <= 1'b1;
                if (out_we)
                    out_vld_reg[addr_b] <= 1'b1;
            end
        end
    end

    assign res_valid        = s2_reg.valid;
    assign res.window_match = match;
    assign res.found        = found_next;
    assign res.pattern_full = s2_reg.full_flag;
    assign busy             = s2_reg.valid;

    a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nz_reg) <= ALPHABET)
        else $error("mismatch count beyond alphabet size");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.valid && s2_reg.clear |=> nz_reg == '0 && !found_reg)
        else $error("clear left histogram state behind");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && !(s2_reg.valid && s2_reg.clear) |=> found_reg)
        else $error("found flag dropped without clear");

endmodule

[rtl/swam_outq.sv]
// Result queue that parts the pipeline from the output handshake.
module swam_outq import swam_pkg::*; #(
    parameter int DEPTH = OUTQ_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  swam_result_t               din,
    swam_out_if.source                 result,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    swam_result_t  q_mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [LW-1:0] level_reg, level_next;
    logic          pop;
    swam_result_t  head;

    assign pop  = result.valid && result.ready;
    assign head = q_mem[rd_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + LW'(1);
        else if (pop && !push)
            level_next = level_reg - LW'(1);
    end

    // Store the beat at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
    end

    assign result.valid        = (level_reg != '0);
    assign result.window_match = head.window_match;
    assign result.found        = head.found;
    assign result.pattern_full = head.pattern_full;
    assign level               = level_reg;

endmodule

[rtl/sliding_window_anagram_match_unit.sv]
// Top level of the sliding window anagram match unit.
//
// Usage: beats on item carry op and letter. Op clear drops pattern, window and
// flags; op pattern adds a letter to the pattern (refused with pattern_full once
// MAX_PATTERN letters are held); op text shifts a letter into the window. Every
// accepted beat gives exactly one beat on result: window_match, the sticky found
// flag and the sticky pattern_full flag. Letters at or above ALPHABET are ignored.
// A result passes the front end register, the histogram register and the queue.
// Throughput: one item per cycle while item.ready is high. Each text letter
// costs one read-modify-write of two histogram memories (two read ports, one
// write port each) and one read of the letter ring; a running count of differing
// letters stands in for the full histogram compare, with last-write forwarding
// covering back-to-back letters.
// Reset: all counts read as zero through per-entry valid bits, so the block takes
// items as soon as reset is released, with no clearing pass.
// Stall: results wait in a four-entry queue; item.ready drops when the queue and
// the items in flight fill it, and rises again as results are taken.
module sliding_window_anagram_match_unit import swam_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int ALPHABET    = ALPHABET_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    swam_in_if.sink    item,
    swam_out_if.source result
);

    localparam int LW = $clog2(OUTQ_DEPTH + 1);
    localparam int SW = LW + 1;

    logic          accept;
    swam_stage_t   stage;
    logic          res_valid;
    swam_result_t  res;
    logic          busy;
    logic [LW-1:0] level;
    logic [SW-1:0] used;

    // Credit: queue entries plus beats still in the pipeline
    assign used       = SW'(level) + SW'(stage.valid) + SW'(busy);
    assign item.ready = (used < SW'(OUTQ_DEPTH));
    assign accept     = item.valid && item.ready;

    swam_ctrl #(
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (item.op),
        .letter (item.letter),
        .stage  (stage)
    );

    swam_hist #(
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .res_valid (res_valid),
        .res       (res),
        .busy      (busy)
    );

    swam_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_valid),
        .din    (res),
        .result (result),
        .level  (level)
    );

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        used <= SW'(OUTQ_DEPTH))
        else $error("result queue overcommitted");

endmodule
